/* hw/rtl/affra_pkg.sv */
// ----------------------------------------------------------------------------
// affra_pkg : shared types and constants of the range allocator
// Beat payloads, free-table entry layout and cell command codes.
// ----------------------------------------------------------------------------
package affra_pkg;

   localparam logic [31:0] HEAP_RESET = 32'hFFFF_FFFF;
   localparam int          REM_STEPS  = 32;

   // cell commands
   localparam logic [2:0] CELL_HOLD   = 3'd0;
   localparam logic [2:0] CELL_ROTATE = 3'd1;
   localparam logic [2:0] CELL_WRITE  = 3'd2;
   localparam logic [2:0] CELL_INSERT = 3'd3;
   localparam logic [2:0] CELL_REMOVE = 3'd4;
   localparam logic [2:0] CELL_INIT   = 3'd5;

   typedef struct packed {
      logic        operation;
      logic [31:0] length;
      logic [31:0] alignment;
      logic [31:0] base_offset;
   } req_type;

   typedef struct packed {
      logic [31:0] range_offset;
      logic [31:0] range_size;
      logic        failed;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] off;
      logic [32:0] size;
   } entry_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] off;
      logic [32:0] size;
   } cell_cmd_type;

endpackage

/* hw/rtl/affra_cell.sv */
// ----------------------------------------------------------------------------
// affra_cell : one free-table entry
// Holds one range; rotates, shifts or loads under a broadcast command.
// ----------------------------------------------------------------------------
module affra_cell #(
   parameter int IDX_W = 6,
   parameter int IDX   = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  affra_pkg::cell_cmd_type  cmd_i,
   input  logic [IDX_W-1:0]         idx_i,
   input  affra_pkg::entry_type     left_i,
   input  affra_pkg::entry_type     right_i,
   output affra_pkg::entry_type     ent_o
);

   localparam logic [IDX_W-1:0] MY = IDX_W'(IDX);

   affra_pkg::entry_type ent_ff, ent_in, new_ent;

   assign new_ent = '{valid: 1'b1, off: cmd_i.off, size: cmd_i.size};

   always_comb begin
      ent_in = ent_ff;
      case (cmd_i.op)
         affra_pkg::CELL_ROTATE: ent_in = right_i;
         affra_pkg::CELL_WRITE: begin
            if (idx_i == MY) ent_in = new_ent;
         end
         affra_pkg::CELL_INSERT: begin
            if (idx_i == MY) ent_in = new_ent;
            else if (MY > idx_i) ent_in = left_i;
         end
         affra_pkg::CELL_REMOVE: begin
            if (MY >= idx_i) ent_in = right_i;
         end
         affra_pkg::CELL_INIT: begin
            if (IDX == 0) ent_in = '{valid: (cmd_i.size != 33'd0), off: cmd_i.off,
                                     size: cmd_i.size};
            else ent_in = '0;
         end
         default: ent_in = ent_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_ff.valid <= (IDX == 0);
         ent_ff.off   <= 32'd0;
         ent_ff.size  <= {1'b0, affra_pkg::HEAP_RESET};
      end else begin
         ent_ff <= ent_in;
      end
   end

   assign ent_o = ent_ff;

endmodule

/* hw/rtl/affra_rem.sv */
// ----------------------------------------------------------------------------
// affra_rem : iterative remainder unit
// Restoring division, one bit a cycle; gives dividend mod divisor.
// ----------------------------------------------------------------------------
module affra_rem (
   input  logic        clock,
   input  logic        reset,
   input  logic        start_i,
   input  logic [31:0] dividend_i,
   input  logic [31:0] divisor_i,
   output logic        done_o,
   output logic [31:0] rem_o
);

   logic        active_ff, done_ff;
   logic [4:0]  step_ff;
   logic [31:0] quo_ff, rem_ff, dsr_ff;
   logic [32:0] trial;

   assign trial = {rem_ff, quo_ff[31]};

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         step_ff   <= 5'd0;
      end else begin
         done_ff <= 1'b0;
         if (start_i) begin
            active_ff <= 1'b1;
            step_ff   <= 5'd0;
         end else if (active_ff) begin
            step_ff <= step_ff + 5'd1;
            if (step_ff == 5'(affra_pkg::REM_STEPS - 1)) begin
               active_ff <= 1'b0;
               done_ff   <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start_i) begin
         quo_ff <= dividend_i;
         rem_ff <= 32'd0;
         dsr_ff <= divisor_i;
      end else if (active_ff) begin
         quo_ff <= {quo_ff[30:0], 1'b0};
         if (trial >= {1'b0, dsr_ff}) rem_ff <= 32'(trial - {1'b0, dsr_ff});
         else rem_ff <= trial[31:0];
      end
   end

   assign done_o = done_ff;
   assign rem_o  = rem_ff;

endmodule

/* hw/rtl/aligned_first_fit_range_allocator_core.sv */
// ----------------------------------------------------------------------------
// aligned_first_fit_range_allocator_core : aligned first-fit range allocator
// Offset-sorted free table held in a row of cells, with merge on free.
// ----------------------------------------------------------------------------
// A request beat is taken when start is high and busy is low; one response
// beat follows on rsp_strobe for exactly one cycle and the receiver cannot
// stall it. Each request rotates the whole table of MAX_RANGES cells once
// past the head cell; an allocate whose alignment is not a power of two
// also runs the remainder unit (one bit a cycle) on every entry inspected;
// only entries large enough are inspected, and only until the first fit.
// Writing csr_wdata (heap size) resets the table to one range (0, heap
// size), or empty for size zero; it is accepted only while idle and no
// request beat is on offer. No clearing pass after reset.
// ----------------------------------------------------------------------------
module aligned_first_fit_range_allocator_core #(
   parameter int MAX_RANGES = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  affra_pkg::req_type req_item,
   output logic               rsp_strobe,
   output affra_pkg::rsp_type rsp_item,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [31:0]        csr_wdata
);

   localparam int IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
   localparam int CNT_W = $clog2(MAX_RANGES + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RANGES);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_DIV    = 3'd2;
   localparam logic [2:0] S_DECIDE = 3'd3;
   localparam logic [2:0] S_WRITE  = 3'd4;
   localparam logic [2:0] S_SHIFT  = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in, rot_ff, rot_in, fidx_ff, fidx_in;
   logic             found_ff, found_in;

   // latched request: len is 33 bits so a clipped free can reach 2^32
   logic             op_ff;
   logic [32:0]      len_ff;
   logic [31:0]      align_ff, base_ff;

   // candidate (allocate) or previous neighbour (free), and next neighbour
   logic [31:0]      a_off_ff, a_off_in, pad_ff, pad_in, n_off_ff, n_off_in;
   logic [32:0]      a_size_ff, a_size_in, n_size_ff, n_size_in;

   // table edits decided once the scan is over
   logic             do_wr_ff, do_wr_in, do_sh_ff, do_sh_in;
   logic [IDX_W-1:0] wr_idx_ff, wr_idx_in, sh_idx_ff, sh_idx_in;
   logic [31:0]      wr_off_ff, wr_off_in, sh_off_ff, sh_off_in;
   logic [32:0]      wr_size_ff, wr_size_in, sh_size_ff, sh_size_in;
   logic [2:0]       sh_op_ff, sh_op_in;

   affra_pkg::rsp_type rsp_ff, rsp_in;
   logic               strobe_ff, strobe_in;

   affra_pkg::cell_cmd_type cmd;
   logic [IDX_W-1:0]        cmd_idx;
   affra_pkg::entry_type    ent [MAX_RANGES];
   affra_pkg::entry_type    head, wrap;

   logic        div_start, div_done;
   logic [31:0] div_rem;

   logic        accept, csr_fire;

   assign accept    = start && !busy;
   assign busy      = (state_ff != S_IDLE);
   // a request on offer takes the idle slot, so the two never meet
   assign csr_ready = (state_ff == S_IDLE) && !start;
   assign csr_fire  = csr_valid && csr_ready;
   assign head      = ent[0];
   assign wrap      = (cmd.op == affra_pkg::CELL_ROTATE) ? ent[0] : '0;

   // ---------------- cell row ----------------
   for (genvar k = 0; k < MAX_RANGES; k++) begin : g_cell
      affra_pkg::entry_type left_w, right_w;
      if (k == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_left
         assign left_w = ent[k-1];
      end
      if (k == MAX_RANGES - 1) begin : g_last
         assign right_w = wrap;
      end else begin : g_right
         assign right_w = ent[k+1];
      end
      affra_cell #(.IDX_W(IDX_W), .IDX(k)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .cmd_i   (cmd),
         .idx_i   (cmd_idx),
         .left_i  (left_w),
         .right_i (right_w),
         .ent_o   (ent[k])
      );
   end

   affra_rem u_rem (
      .clock      (clock),
      .reset      (reset),
      .start_i    (div_start),
      .dividend_i (head.off),
      .divisor_i  (align_ff),
      .done_o     (div_done),
      .rem_o      (div_rem)
   );

   // ---------------- alignment check on the head entry ----------------
   logic        in_range, pow2, pad_zero_rem;
   logic [31:0] pad_now;
   logic [32:0] aligned33;
   logic        fits, bigger, is_scan_rot;

   assign in_range     = (rot_ff < count_ff);
   assign pow2         = ((align_ff & (align_ff - 32'd1)) == 32'd0);
   assign pad_zero_rem = (div_rem == 32'd0);
   assign pad_now      = (state_ff == S_DIV) ?
                         (pad_zero_rem ? 32'd0 : align_ff - div_rem) :
                         ((~head.off + 32'd1) & (align_ff - 32'd1));
   assign aligned33    = {1'b0, head.off} + {1'b0, pad_now};
   assign fits         = !aligned33[32] &&
                         (({2'b0, pad_now} + {1'b0, len_ff}) <= {1'b0, head.size});
   assign bigger       = (head.size >= len_ff) && (len_ff != 33'd0);

   // candidate worth a look during an allocate scan
   logic alloc_look;
   assign alloc_look  = !op_ff && in_range && !found_ff && bigger;
   assign is_scan_rot = (state_ff == S_SCAN) && (rot_ff != CNT_MAX) &&
                        !(alloc_look && !pow2);
   assign div_start   = (state_ff == S_SCAN) && (rot_ff != CNT_MAX) && alloc_look && !pow2;

   // ---------------- decision after the scan ----------------
   logic [CNT_W-1:0] idx_f, idx_m1;
   logic [32:0]      aligned_d, tail_d;
   logic [31:0]      end_new;
   logic [33:0]      prev_end, base34, blen;
   logic             prev_ex, mp, mn;

   assign idx_f     = found_ff ? fidx_ff : count_ff;
   assign idx_m1    = idx_f - CNT_W'(1);
   assign aligned_d = {1'b0, a_off_ff} + {1'b0, pad_ff};
   assign tail_d    = a_size_ff - {1'b0, pad_ff} - len_ff;
   assign end_new   = aligned_d[31:0] + len_ff[31:0];
   assign prev_end  = {2'b0, a_off_ff} + {1'b0, a_size_ff};
   assign base34    = {2'b0, base_ff};
   assign blen      = base34 + {1'b0, len_ff};
   assign prev_ex   = (idx_f != '0);
   assign mp        = prev_ex && (prev_end == base34);
   assign mn        = found_ff && (blen == {2'b0, n_off_ff});

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      rot_in     = rot_ff;
      fidx_in    = fidx_ff;
      found_in   = found_ff;
      a_off_in   = a_off_ff;
      a_size_in  = a_size_ff;
      pad_in     = pad_ff;
      n_off_in   = n_off_ff;
      n_size_in  = n_size_ff;
      do_wr_in   = do_wr_ff;
      do_sh_in   = do_sh_ff;
      wr_idx_in  = wr_idx_ff;
      wr_off_in  = wr_off_ff;
      wr_size_in = wr_size_ff;
      sh_idx_in  = sh_idx_ff;
      sh_off_in  = sh_off_ff;
      sh_size_in = sh_size_ff;
      sh_op_in   = sh_op_ff;
      rsp_in     = rsp_ff;
      strobe_in  = 1'b0;
      cmd        = '{op: affra_pkg::CELL_HOLD, off: 32'd0, size: 33'd0};
      cmd_idx    = '0;

      case (state_ff)
         S_IDLE: begin
            if (csr_fire) begin
               cmd      = '{op: affra_pkg::CELL_INIT, off: 32'd0, size: {1'b0, csr_wdata}};
               count_in = (csr_wdata != 32'd0) ? CNT_W'(1) : '0;
            end else if (accept) begin
               state_in = S_SCAN;
               rot_in   = '0;
               found_in = 1'b0;
               do_wr_in = 1'b0;
               do_sh_in = 1'b0;
            end
         end
         S_SCAN: begin
            if (rot_ff == CNT_MAX) begin
               state_in = S_DECIDE;
            end else if (div_start) begin
               state_in = S_DIV;
            end else begin
               if (alloc_look && fits) begin
                  found_in  = 1'b1;
                  fidx_in   = rot_ff;
                  a_off_in  = head.off;
                  a_size_in = head.size;
                  pad_in    = pad_now;
               end
               if (op_ff && in_range && !found_ff) begin
                  if (head.off > base_ff) begin
                     found_in  = 1'b1;
                     fidx_in   = rot_ff;
                     n_off_in  = head.off;
                     n_size_in = head.size;
                  end else begin
                     a_off_in  = head.off;
                     a_size_in = head.size;
                  end
               end
            end
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_SCAN;
               if (fits) begin
                  found_in  = 1'b1;
                  fidx_in   = rot_ff;
                  a_off_in  = head.off;
                  a_size_in = head.size;
                  pad_in    = pad_now;
               end
            end
         end
         S_DECIDE: begin
            state_in = S_WRITE;
            rsp_in   = '0;
            if (!op_ff) begin
               if (!found_ff) begin
                  rsp_in.failed = 1'b1;
               end else if (pad_ff != 32'd0 && tail_d != 33'd0 && count_ff >= CNT_MAX) begin
                  rsp_in.failed = 1'b1;
               end else begin
                  rsp_in.range_offset = aligned_d[31:0];
                  rsp_in.range_size   = len_ff[31:0];
                  if (pad_ff != 32'd0) begin
                     do_wr_in   = 1'b1;
                     wr_idx_in  = fidx_ff[IDX_W-1:0];
                     wr_off_in  = a_off_ff;
                     wr_size_in = {1'b0, pad_ff};
                     if (tail_d != 33'd0) begin
                        do_sh_in   = 1'b1;
                        sh_op_in   = affra_pkg::CELL_INSERT;
                        sh_idx_in  = IDX_W'(fidx_ff + CNT_W'(1));
                        sh_off_in  = end_new;
                        sh_size_in = tail_d;
                     end
                  end else if (tail_d != 33'd0) begin
                     do_wr_in   = 1'b1;
                     wr_idx_in  = fidx_ff[IDX_W-1:0];
                     wr_off_in  = end_new;
                     wr_size_in = tail_d;
                  end else begin
                     do_sh_in  = 1'b1;
                     sh_op_in  = affra_pkg::CELL_REMOVE;
                     sh_idx_in = fidx_ff[IDX_W-1:0];
                  end
               end
            end else if (len_ff != 33'd0) begin
               if (prev_ex && prev_end > base34) begin
                  rsp_in.failed = 1'b1;
               end else if (found_ff && blen > {2'b0, n_off_ff}) begin
                  rsp_in.failed = 1'b1;
               end else if (mp) begin
                  do_wr_in   = 1'b1;
                  wr_idx_in  = idx_m1[IDX_W-1:0];
                  wr_off_in  = a_off_ff;
                  wr_size_in = mn ? 33'(a_size_ff + len_ff + n_size_ff) : a_size_ff + len_ff;
                  if (mn) begin
                     do_sh_in  = 1'b1;
                     sh_op_in  = affra_pkg::CELL_REMOVE;
                     sh_idx_in = idx_f[IDX_W-1:0];
                  end
               end else if (mn) begin
                  do_wr_in   = 1'b1;
                  wr_idx_in  = idx_f[IDX_W-1:0];
                  wr_off_in  = base_ff;
                  wr_size_in = n_size_ff + len_ff;
               end else if (count_ff >= CNT_MAX) begin
                  rsp_in.failed = 1'b1;
               end else begin
                  do_sh_in   = 1'b1;
                  sh_op_in   = affra_pkg::CELL_INSERT;
                  sh_idx_in  = idx_f[IDX_W-1:0];
                  sh_off_in  = base_ff;
                  sh_size_in = len_ff;
               end
            end
         end
         S_WRITE: begin
            state_in = S_SHIFT;
            if (do_wr_ff) begin
               cmd     = '{op: affra_pkg::CELL_WRITE, off: wr_off_ff, size: wr_size_ff};
               cmd_idx = wr_idx_ff;
            end
         end
         S_SHIFT: begin
            state_in = S_DONE;
            if (do_sh_ff) begin
               cmd     = '{op: sh_op_ff, off: sh_off_ff, size: sh_size_ff};
               cmd_idx = sh_idx_ff;
               if (sh_op_ff == affra_pkg::CELL_INSERT) count_in = count_ff + CNT_W'(1);
               else count_in = count_ff - CNT_W'(1);
            end
         end
         S_DONE: begin
            state_in  = S_IDLE;
            strobe_in = 1'b1;
         end
         default: state_in = S_IDLE;
      endcase

      // one step of the rotation: head goes to the tail, ring index moves on
      if (is_scan_rot || (state_ff == S_DIV && div_done)) begin
         cmd    = '{op: affra_pkg::CELL_ROTATE, off: 32'd0, size: 33'd0};
         rot_in = rot_ff + CNT_W'(1);
      end
   end

   // free clipped so that it ends at 2^32
   logic [33:0] req_end;
   logic        clip;
   assign req_end = {2'b0, req_item.base_offset} + {2'b0, req_item.length};
   assign clip    = req_end[33] || (req_end[32] && (req_end[31:0] != 32'd0));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= CNT_W'(1);
         rot_ff    <= '0;
         found_ff  <= 1'b0;
         do_wr_ff  <= 1'b0;
         do_sh_ff  <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         rot_ff    <= rot_in;
         found_ff  <= found_in;
         do_wr_ff  <= do_wr_in;
         do_sh_ff  <= do_sh_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !csr_fire) begin
         op_ff    <= req_item.operation;
         align_ff <= (req_item.alignment == 32'd0) ? 32'd1 : req_item.alignment;
         base_ff  <= req_item.base_offset;
         if (req_item.operation && clip) len_ff <= 33'h1_0000_0000 - {1'b0, req_item.base_offset};
         else len_ff <= {1'b0, req_item.length};
      end
      fidx_ff    <= fidx_in;
      a_off_ff   <= a_off_in;
      a_size_ff  <= a_size_in;
      pad_ff     <= pad_in;
      n_off_ff   <= n_off_in;
      n_size_ff  <= n_size_in;
      wr_idx_ff  <= wr_idx_in;
      wr_off_ff  <= wr_off_in;
      wr_size_ff <= wr_size_in;
      sh_idx_ff  <= sh_idx_in;
      sh_off_ff  <= sh_off_in;
      sh_size_ff <= sh_size_in;
      sh_op_ff   <= sh_op_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

   // ---------------- checks ----------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_MAX) else $error("free count beyond table depth");

   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("response beat repeated");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.failed |-> rsp_item.range_offset == 32'd0 &&
      rsp_item.range_size == 32'd0) else $error("failed beat carries a range");

   a_ring_home: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DECIDE |-> rot_ff == CNT_MAX) else $error("ring not back home");

   a_head_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE && count_ff != '0 |-> ent[0].valid)
      else $error("first entry invalid with non-empty table");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top : self-checking bench for the aligned first-fit range allocator
// Random and directed allocate/free beats are predicted against a shadow
// free table and every response beat is checked field by field.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int      TABLE_DEPTH = 64;
   localparam bit      OP_ALLOC    = 1'b0;
   localparam bit      OP_FREE     = 1'b1;
   localparam longint  ADDR_TOP    = 64'h1_0000_0000;
   localparam longint  ADDR_MASK   = 64'hFFFF_FFFF;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   affra_pkg::req_type req_item = '0;
   logic               rsp_strobe;
   affra_pkg::rsp_type rsp_item;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [31:0]        csr_wdata = '0;

   aligned_first_fit_range_allocator_core #(.MAX_RANGES(TABLE_DEPTH)) DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_strobe(rsp_strobe), .rsp_item(rsp_item),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   // shadow free table, sorted by offset
   longint  shadow_off [TABLE_DEPTH];
   longint  shadow_sz  [TABLE_DEPTH];
   int      shadow_cnt;

   affra_pkg::req_type pending_reqs [$];
   affra_pkg::rsp_type expected_rsps [$];
   int      error_count = 0;

   // live allocations, so frees can hand most of them back
   longint  live_off [$];
   longint  live_len [$];

   function automatic void table_reset(logic [31:0] heap);
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         shadow_off[i] = 0;
         shadow_sz[i]  = 0;
      end
      shadow_cnt = 0;
      if (heap != 0) begin
         shadow_sz[0] = heap;
         shadow_cnt   = 1;
      end
   endfunction

   function automatic void table_remove(int idx);
      for (int i = idx; i < shadow_cnt - 1; i++) begin
         shadow_off[i] = shadow_off[i+1];
         shadow_sz[i]  = shadow_sz[i+1];
      end
      shadow_cnt--;
      shadow_off[shadow_cnt] = 0;
      shadow_sz[shadow_cnt]  = 0;
   endfunction

   function automatic void table_insert(int idx, longint off, longint sz);
      for (int i = shadow_cnt; i > idx; i--) begin
         shadow_off[i] = shadow_off[i-1];
         shadow_sz[i]  = shadow_sz[i-1];
      end
      shadow_off[idx] = off;
      shadow_sz[idx]  = sz;
      shadow_cnt++;
   endfunction

   // first fit with rounding up; returns the response and updates the table
   function automatic affra_pkg::rsp_type predict_alloc(longint len, longint align);
      affra_pkg::rsp_type r;
      longint  aligned, pad, tail;
      r = '0;
      r.failed = 1'b1;
      if (align == 0) align = 1;
      if (len == 0) return r;
      for (int i = 0; i < shadow_cnt; i++) begin
         aligned = ((shadow_off[i] + align - 1) / align) * align;
         pad     = aligned - shadow_off[i];
         if (aligned > ADDR_MASK || pad > shadow_sz[i] || shadow_sz[i] - pad < len) continue;
         tail = shadow_sz[i] - pad - len;
         if (pad != 0 && tail != 0) begin
            if (shadow_cnt >= TABLE_DEPTH) return r;
            shadow_sz[i] = pad;
            table_insert(i + 1, aligned + len, tail);
         end else if (pad != 0) begin
            shadow_sz[i] = pad;
         end else if (tail != 0) begin
            shadow_off[i] = aligned + len;
            shadow_sz[i]  = tail;
         end else begin
            table_remove(i);
         end
         r.failed       = 1'b0;
         r.range_offset = aligned[31:0];
         r.range_size   = len[31:0];
         return r;
      end
      return r;
   endfunction

   // returns 1 when the free is refused
   function automatic bit predict_free(longint base, longint len);
      int idx;
      bit mp, mn;
      idx = shadow_cnt;
      if (len == 0) return 1'b0;
      if (base + len > ADDR_TOP) len = ADDR_TOP - base;
      for (int i = 0; i < shadow_cnt; i++)
         if (shadow_off[i] > base) begin
            idx = i;
            break;
         end
      if (idx > 0 && shadow_off[idx-1] + shadow_sz[idx-1] > base) return 1'b1;
      if (idx < shadow_cnt && base + len > shadow_off[idx]) return 1'b1;
      mp = idx > 0 && shadow_off[idx-1] + shadow_sz[idx-1] == base;
      mn = idx < shadow_cnt && base + len == shadow_off[idx];
      if (mp && mn) begin
         shadow_sz[idx-1] += len + shadow_sz[idx];
         table_remove(idx);
      end else if (mp) begin
         shadow_sz[idx-1] += len;
      end else if (mn) begin
         shadow_off[idx] = base;
         shadow_sz[idx] += len;
      end else begin
         if (shadow_cnt >= TABLE_DEPTH) return 1'b1;
         table_insert(idx, base, len);
      end
      return 1'b0;
   endfunction

   function automatic affra_pkg::rsp_type predict_rsp(affra_pkg::req_type q);
      affra_pkg::rsp_type r;
      r = '0;
      if (q.operation == OP_ALLOC) r = predict_alloc(longint'(q.length), longint'(q.alignment));
      else r.failed = predict_free(longint'(q.base_offset), longint'(q.length));
      return r;
   endfunction

   // driver: random gap before each beat, prediction on acceptance
   int gap_left = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            expected_rsps.push_back(predict_rsp(req_item));
            if (pending_reqs.size() > 0 && gap_left == 0) begin
               req_item <= pending_reqs.pop_front();
               gap_left <= $urandom_range(0, 6);
            end else begin
               start <= 1'b0;
            end
         end else if (!start && pending_reqs.size() > 0) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
            end else begin
               req_item <= pending_reqs.pop_front();
               start    <= 1'b1;
               gap_left <= $urandom_range(0, 6);
            end
         end
      end
   end

   // monitor: one response beat per strobe, compared with the oldest prediction
   always @(posedge clock) begin
      affra_pkg::rsp_type e;
      if (!reset && rsp_strobe) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t unexpected response exp none got %h", $time, rsp_item);
            error_count++;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_item.range_offset !== e.range_offset)
               $display("%0t range_offset exp %h got %h", $time, e.range_offset,
                        rsp_item.range_offset);
            if (rsp_item.range_size !== e.range_size)
               $display("%0t range_size exp %h got %h", $time, e.range_size,
                        rsp_item.range_size);
            if (rsp_item.failed !== e.failed)
               $display("%0t failed exp %b got %b", $time, e.failed, rsp_item.failed);
            if (rsp_item !== e) error_count++;
         end
      end
   end

   function automatic affra_pkg::req_type make_req(bit op, logic [31:0] len,
                                                   logic [31:0] align, logic [31:0] base);
      affra_pkg::req_type q;
      q.operation = op; q.length = len; q.alignment = align; q.base_offset = base;
      return q;
   endfunction

   function automatic logic [31:0] rand_align();
      case ($urandom_range(0, 5))
         0: return 32'd1;
         1: return 32'd1 << $urandom_range(0, 31);
         2: return $urandom_range(3, 100);
         3: return 32'd0;
         4: return $urandom();
         default: return 32'd1 << $urandom_range(0, 8);
      endcase
   endfunction

   // sampled at the falling edge, once every update of the rising edge has settled
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || start || busy || expected_rsps.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_heap(logic [31:0] heap);
      @(posedge clock);
      csr_wdata <= heap;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      table_reset(heap);
      live_off.delete();
      live_len.delete();
   endtask

   // a phase of random traffic: mostly allocs and returns of live ranges
   task automatic random_phase(int n, logic [31:0] heap);
      longint o, l;
      int k;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: pending_reqs.push_back(make_req(OP_ALLOC,
                  $urandom_range(1, 3) == 1 ? $urandom() : $urandom_range(1, 2 * heap / 64 + 1),
                  rand_align(), $urandom()));
            4, 5, 6: begin
               // hand back a previously issued range in full
               if (live_off.size() > 0) begin
                  k = $urandom_range(0, live_off.size() - 1);
                  o = live_off[k]; l = live_len[k];
                  live_off.delete(k); live_len.delete(k);
                  pending_reqs.push_back(make_req(OP_FREE, l[31:0], $urandom(), o[31:0]));
               end else
                  pending_reqs.push_back(make_req(OP_FREE, $urandom_range(0, 64),
                     $urandom(), $urandom_range(0, heap)));
            end
            7: pending_reqs.push_back(make_req(OP_FREE, $urandom(), $urandom(), $urandom()));
            8: pending_reqs.push_back(make_req(OP_FREE, $urandom_range(0, 16), $urandom(),
                  $urandom_range(0, heap)));
            default: pending_reqs.push_back(make_req(1'($urandom_range(0, 1)), $urandom(),
                  $urandom(), $urandom()));
         endcase
         // one beat at a time so live ranges are known before the next pick
         wait_drained();
      end
   endtask

   // allocations are tracked by watching accepted alloc responses
   always @(posedge clock) begin
      if (!reset && rsp_strobe && !rsp_item.failed && rsp_item.range_size != 0) begin
         live_off.push_back(rsp_item.range_offset);
         live_len.push_back(rsp_item.range_size);
      end
   end

   initial begin
      table_reset(affra_pkg::HEAP_RESET);
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes and the named special cases on the reset heap
      pending_reqs.push_back(make_req(OP_ALLOC, 32'd0, 32'd1, 32'd0));          // zero length
      pending_reqs.push_back(make_req(OP_ALLOC, 32'd16, 32'd0, 32'hFFFF_FFFF)); // align zero
      pending_reqs.push_back(make_req(OP_ALLOC, 32'd100, 32'd3, 32'd0));        // odd align
      pending_reqs.push_back(make_req(OP_ALLOC, 32'd8, 32'h8000_0000, 32'd0));  // top align
      pending_reqs.push_back(make_req(OP_ALLOC, 32'hFFFF_FFFF, 32'd1, 32'd0));  // no fit
      pending_reqs.push_back(make_req(OP_FREE, 32'd0, 32'd5, 32'd50));          // zero free
      pending_reqs.push_back(make_req(OP_FREE, 32'd4, 32'd1, 32'd2));           // overlap
      pending_reqs.push_back(make_req(OP_FREE, 32'd16, 32'd0, 32'd0));          // merge next
      pending_reqs.push_back(make_req(OP_FREE, 32'd84, 32'd1, 32'd16));         // both sides
      pending_reqs.push_back(make_req(OP_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0));
      wait_drained();

      write_heap(32'd1);
      pending_reqs.push_back(make_req(OP_ALLOC, 32'd1, 32'd1, 32'd0));          // exact fit
      pending_reqs.push_back(make_req(OP_FREE, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF)); // clip
      pending_reqs.push_back(make_req(OP_FREE, 32'd1, 32'd1, 32'd0));           // merge prev? no
      pending_reqs.push_back(make_req(OP_ALLOC, 32'd1, 32'hFFFF_FFFF, 32'd0));  // beyond 32 bit
      wait_drained();

      write_heap(32'd0);                                                        // empty table
      pending_reqs.push_back(make_req(OP_ALLOC, 32'd1, 32'd1, 32'd0));
      pending_reqs.push_back(make_req(OP_FREE, 32'd8, 32'd1, 32'd100));         // append
      pending_reqs.push_back(make_req(OP_FREE, 32'd8, 32'd1, 32'd200));         // append above
      wait_drained();

      // fill the table with gaps: split refusals and insert refusals
      write_heap(32'd4096);
      for (int i = 0; i < 66; i++)
         pending_reqs.push_back(make_req(OP_ALLOC, 32'd1, 32'd2, 32'd0));
      pending_reqs.push_back(make_req(OP_FREE, 32'd1, 32'd1, 32'd5000));
      wait_drained();

      // random phases across several heap sizes
      begin
         logic [31:0] heaps [5];
         heaps = '{32'd64, 32'd4096, 32'h0010_0000, 32'hFFFF_FFFF, 32'd1024};
         for (int p = 0; p < 5; p++) begin
            write_heap(heaps[p]);
            random_phase(200, heaps[p]);
            wait_drained();
         end
      end

      wait_drained();
      repeat (200) @(posedge clock);
      if (error_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

   initial begin
      #100_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
